/* design/rtch_pkg.sv */
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types and constants of the ray/triangle closest-hit unit.
// ----------------------------------------------------------------------------
package rtch_pkg;

  localparam int WORD_W      = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic signed [WORD_W-1:0] vertex0_x;
    logic signed [WORD_W-1:0] vertex0_y;
    logic signed [WORD_W-1:0] vertex0_z;
    logic signed [WORD_W-1:0] vertex1_x;
    logic signed [WORD_W-1:0] vertex1_y;
    logic signed [WORD_W-1:0] vertex1_z;
    logic signed [WORD_W-1:0] vertex2_x;
    logic signed [WORD_W-1:0] vertex2_y;
    logic signed [WORD_W-1:0] vertex2_z;
    logic                     last_triangle;
  } triangle_t;

  typedef struct packed {
    logic                     any_hit;
    logic [9:0]               hit_index;
    logic [30:0]              hit_distance;
    logic signed [WORD_W-1:0] hit_x;
    logic signed [WORD_W-1:0] hit_y;
    logic signed [WORD_W-1:0] hit_z;
  } result_t;

endpackage

/* design/ray_triangle_closest_hit.sv */
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// Processing: each triangle runs its cross and dot products and the squared
// ray length through the shared 34x34 multiplier, then the inside test; a
// triangle that passes it goes through the one-bit-per-cycle divider and the
// distance product; after the last triangle the hit point is computed.
// One triangle at a time; a triangle past MAX_TRIANGLES is not tested.
// The result register lets the next triangle in while a result waits.
// Reset: synchronous; clears ray registers, best hit and counter.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit #(
  parameter int MAX_TRIANGLES = 1024,
  parameter int FRAC_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 triangle_valid,
  output logic                                 triangle_ready,
  input  rtch_pkg::triangle_t                  triangle,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output rtch_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtch_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rtch_pkg::WORD_W-1:0]          cfg_data
);

  localparam int CNT_W     = $clog2(MAX_TRIANGLES + 1);
  localparam int ACC_W     = 67 - FRAC_BITS;
  localparam int QUO_W     = 32 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DIST = 3'd4;
  localparam logic [2:0] S_POS  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  function automatic logic signed [31:0] sat_diff(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_wide(input logic signed [68:0] x);
    if ((&x[68:31]) || !(|x[68:31])) begin
      return x[31:0];
    end
    return x[68] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  logic [2:0]               state;
  logic signed [31:0]       org [3];
  logic signed [31:0]       dir [3];
  logic signed [31:0]       e1 [3];
  logic signed [31:0]       e2 [3];
  logic signed [31:0]       bv [3];
  logic signed [31:0]       c12 [3];
  logic signed [31:0]       cb2 [3];
  logic signed [31:0]       c1b [3];
  logic signed [31:0]       dot_det, dot_nt, dot_nu, dot_nv;
  logic signed [31:0]       pos [3];
  logic [5:0]               step;
  logic                     ph;
  logic [1:0]               kpos;
  logic signed [67:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic [63:0]              sq;
  logic [31:0]              det_abs;
  logic [QUO_W-1:0]         dvd;
  logic [QUO_W-1:0]         quo;
  logic [31:0]              rem;
  logic [DIV_CNT_W-1:0]     dcnt;
  logic [63:0]              sn, sres, sbit;
  logic [31:0]              best_distance;
  logic [30:0]              best_param;
  logic [CNT_W-1:0]         best_slot;
  logic                     seen_hit;
  logic [CNT_W-1:0]         triangle_counter;
  logic                     last_flag;

  // multiplier operand selection
  logic signed [31:0]       ta, tb;
  logic signed [33:0]       ma, mb;
  logic                     mul_first, mul_sub, mul_store;

  always_comb begin
    ta = '0;
    tb = '0;
    case (step)
      6'd0:  begin ta = e1[1];  tb = e2[2];  end
      6'd1:  begin ta = e1[2];  tb = e2[1];  end
      6'd2:  begin ta = e1[2];  tb = e2[0];  end
      6'd3:  begin ta = e1[0];  tb = e2[2];  end
      6'd4:  begin ta = e1[0];  tb = e2[1];  end
      6'd5:  begin ta = e1[1];  tb = e2[0];  end
      6'd6:  begin ta = bv[1];  tb = e2[2];  end
      6'd7:  begin ta = bv[2];  tb = e2[1];  end
      6'd8:  begin ta = bv[2];  tb = e2[0];  end
      6'd9:  begin ta = bv[0];  tb = e2[2];  end
      6'd10: begin ta = bv[0];  tb = e2[1];  end
      6'd11: begin ta = bv[1];  tb = e2[0];  end
      6'd12: begin ta = e1[1];  tb = bv[2];  end
      6'd13: begin ta = e1[2];  tb = bv[1];  end
      6'd14: begin ta = e1[2];  tb = bv[0];  end
      6'd15: begin ta = e1[0];  tb = bv[2];  end
      6'd16: begin ta = e1[0];  tb = bv[1];  end
      6'd17: begin ta = e1[1];  tb = bv[0];  end
      6'd18: begin ta = dir[0]; tb = c12[0]; end
      6'd19: begin ta = dir[1]; tb = c12[1]; end
      6'd20: begin ta = dir[2]; tb = c12[2]; end
      6'd21: begin ta = bv[0];  tb = c12[0]; end
      6'd22: begin ta = bv[1];  tb = c12[1]; end
      6'd23: begin ta = bv[2];  tb = c12[2]; end
      6'd24: begin ta = dir[0]; tb = cb2[0]; end
      6'd25: begin ta = dir[1]; tb = cb2[1]; end
      6'd26: begin ta = dir[2]; tb = cb2[2]; end
      6'd27: begin ta = dir[0]; tb = c1b[0]; end
      6'd28: begin ta = dir[1]; tb = c1b[1]; end
      6'd29: begin ta = dir[2]; tb = c1b[2]; end
      6'd30: begin ta = dir[0]; tb = dir[0]; end
      6'd31: begin ta = dir[1]; tb = dir[1]; end
      6'd32: begin ta = dir[2]; tb = dir[2]; end
      default: begin ta = '0; tb = '0; end
    endcase
  end

  always_comb begin
    if (step < 6'd18) begin
      mul_first = !step[0];
      mul_sub   = step[0];
      mul_store = step[0];
    end else begin
      mul_first = (step == 6'd18) || (step == 6'd21) || (step == 6'd24) || (step == 6'd27);
      mul_sub   = 1'b0;
      mul_store = (step == 6'd20) || (step == 6'd23) || (step == 6'd26) || (step == 6'd29);
    end
  end

  logic [30:0]        t_sat;
  logic signed [31:0] dir_k, org_k;

  always_comb begin
    case (kpos)
      2'd0:    begin dir_k = dir[0]; org_k = org[0]; end
      2'd1:    begin dir_k = dir[1]; org_k = org[1]; end
      default: begin dir_k = dir[2]; org_k = org[2]; end
    endcase
  end

  assign t_sat = (quo > QUO_W'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : quo[30:0];

  always_comb begin
    case (state)
      S_DIST:  begin ma = {3'b000, t_sat};      mb = {1'b0, sres[32:0]}; end
      S_POS:   begin ma = {3'b000, best_param}; mb = sx34(dir_k);        end
      default: begin ma = sx34(ta);             mb = sx34(tb);           end
    endcase
  end

  // accumulate path
  logic signed [67:0]      q68;
  logic signed [ACC_W-1:0] qn, acc_base, acc_next;
  logic signed [31:0]      acc_sat;

  assign q68      = prod >>> FRAC_BITS;
  assign qn       = $signed(q68[ACC_W-1:0]);
  assign acc_base = mul_first ? '0 : acc;
  assign acc_next = mul_sub ? acc_base - qn : acc_base + qn;
  assign acc_sat  = sat_wide({{(69-ACC_W){acc_next[ACC_W-1]}}, acc_next});

  // inside test on normalized numerators
  logic signed [33:0] det_s, nt_s, nu_s, nv_s;
  logic signed [33:0] detn, ntn, nun, nvn;
  logic               neg_det, hit_ok;

  always_comb begin
    det_s   = -sx34(dot_det);
    nt_s    = sx34(dot_nt);
    nu_s    = -sx34(dot_nu);
    nv_s    = -sx34(dot_nv);
    neg_det = det_s < 0;
    detn    = neg_det ? -det_s : det_s;
    ntn     = neg_det ? -nt_s : nt_s;
    nun     = neg_det ? -nu_s : nu_s;
    nvn     = neg_det ? -nv_s : nv_s;
    hit_ok  = (det_s != 0) && (ntn >= 0) && (nun >= 0) && (nvn >= 0) && ((nun + nvn) <= detn);
  end

  // divider and square-root steps
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [64:0] sq_sum;
  logic        sq_ge;

  assign rem_sh = {rem, dvd[QUO_W-1]};
  assign div_ge = rem_sh >= {1'b0, det_abs};
  assign sq_sum = {1'b0, sres} + {1'b0, sbit};
  assign sq_ge  = {1'b0, sn} >= sq_sum;

  // distance and hit point
  logic [67:0]        dist_full;
  logic [30:0]        dist_sat;
  logic signed [68:0] pos_sum;
  logic [31:0]        slot_wide;

  assign dist_full = $unsigned(prod) >> FRAC_BITS;
  assign dist_sat  = (|dist_full[67:31]) ? 31'h7FFF_FFFF : dist_full[30:0];
  assign pos_sum   = {q68[67], q68} + {{37{org_k[31]}}, org_k};
  assign slot_wide = 32'(best_slot);

  assign triangle_ready = (state == S_IDLE);
  assign cfg_ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      step             <= '0;
      ph               <= 1'b0;
      kpos             <= '0;
      dcnt             <= '0;
      best_distance    <= '1;
      best_param       <= '0;
      best_slot        <= '0;
      seen_hit         <= 1'b0;
      triangle_counter <= '0;
      last_flag        <= 1'b0;
      result_valid     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        org[k] <= '0;
        dir[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtch_pkg::REG_ORIGIN_X: org[0] <= cfg_data;
          rtch_pkg::REG_ORIGIN_Y: org[1] <= cfg_data;
          rtch_pkg::REG_ORIGIN_Z: org[2] <= cfg_data;
          rtch_pkg::REG_DIR_X:    dir[0] <= cfg_data;
          rtch_pkg::REG_DIR_Y:    dir[1] <= cfg_data;
          rtch_pkg::REG_DIR_Z:    dir[2] <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && result_ready && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (triangle_valid) begin
            last_flag <= triangle.last_triangle;
            e1[0] <= sat_diff(sx33(triangle.vertex1_x) - sx33(triangle.vertex0_x));
            e1[1] <= sat_diff(sx33(triangle.vertex1_y) - sx33(triangle.vertex0_y));
            e1[2] <= sat_diff(sx33(triangle.vertex1_z) - sx33(triangle.vertex0_z));
            e2[0] <= sat_diff(sx33(triangle.vertex2_x) - sx33(triangle.vertex0_x));
            e2[1] <= sat_diff(sx33(triangle.vertex2_y) - sx33(triangle.vertex0_y));
            e2[2] <= sat_diff(sx33(triangle.vertex2_z) - sx33(triangle.vertex0_z));
            bv[0] <= sat_diff(sx33(org[0]) - sx33(triangle.vertex0_x));
            bv[1] <= sat_diff(sx33(org[1]) - sx33(triangle.vertex0_y));
            bv[2] <= sat_diff(sx33(org[2]) - sx33(triangle.vertex0_z));
            step <= '0;
            ph   <= 1'b0;
            kpos <= '0;
            if (triangle_counter < CNT_W'(MAX_TRIANGLES)) begin
              triangle_counter <= triangle_counter + 1'b1;
              state            <= S_MUL;
            end else if (triangle.last_triangle) begin
              state <= S_POS;
            end
          end
        end

        S_MUL: begin
          if (!ph) begin
            prod <= ma * mb;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (step >= 6'd30) begin
              sq <= ((step == 6'd30) ? 64'd0 : sq) + prod[63:0];
            end else begin
              acc <= acc_next;
            end
            if (mul_store) begin
              case (step)
                6'd1:    c12[0]  <= acc_sat;
                6'd3:    c12[1]  <= acc_sat;
                6'd5:    c12[2]  <= acc_sat;
                6'd7:    cb2[0]  <= acc_sat;
                6'd9:    cb2[1]  <= acc_sat;
                6'd11:   cb2[2]  <= acc_sat;
                6'd13:   c1b[0]  <= acc_sat;
                6'd15:   c1b[1]  <= acc_sat;
                6'd17:   c1b[2]  <= acc_sat;
                6'd20:   dot_det <= acc_sat;
                6'd23:   dot_nt  <= acc_sat;
                6'd26:   dot_nu  <= acc_sat;
                6'd29:   dot_nv  <= acc_sat;
                default: ;
              endcase
            end
            if (step == 6'd32) begin
              state <= S_EVAL;
            end else begin
              step <= step + 1'b1;
            end
          end
        end

        S_EVAL: begin
          det_abs <= detn[31:0];
          dvd     <= {ntn[31:0], {FRAC_BITS{1'b0}}};
          rem     <= '0;
          quo     <= '0;
          dcnt    <= '0;
          sn      <= sq;
          sres    <= '0;
          sbit    <= 64'd1 << 62;
          if (hit_ok) begin
            state <= S_DIV;
          end else begin
            state <= last_flag ? S_POS : S_IDLE;
          end
        end

        S_DIV: begin
          rem  <= div_ge ? 32'(rem_sh - {1'b0, det_abs}) : rem_sh[31:0];
          quo  <= {quo[QUO_W-2:0], div_ge};
          dvd  <= dvd << 1;
          dcnt <= dcnt + 1'b1;
          if (sbit != 64'd0) begin
            if (sq_ge) begin
              sn   <= 64'(({1'b0, sn}) - sq_sum);
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
          if (dcnt == DIV_CNT_W'(QUO_W - 1)) begin
            state <= S_DIST;
            ph    <= 1'b0;
          end
        end

        S_DIST: begin
          if (!ph) begin
            prod <= ma * mb;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if ({1'b0, dist_sat} < best_distance) begin
              best_distance <= {1'b0, dist_sat};
              best_param    <= t_sat;
              best_slot     <= triangle_counter - 1'b1;
              seen_hit      <= 1'b1;
            end
            state <= last_flag ? S_POS : S_IDLE;
          end
        end

        S_POS: begin
          if (!ph) begin
            prod <= ma * mb;
            ph   <= 1'b1;
          end else begin
            ph        <= 1'b0;
            pos[kpos] <= sat_wide(pos_sum);
            if (kpos == 2'd2) begin
              state <= S_EMIT;
            end else begin
              kpos <= kpos + 1'b1;
            end
          end
        end

        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            if (seen_hit) begin
              result.any_hit      <= 1'b1;
              result.hit_index    <= slot_wide[9:0];
              result.hit_distance <= best_distance[30:0];
              result.hit_x        <= pos[0];
              result.hit_y        <= pos[1];
              result.hit_z        <= pos[2];
            end else begin
              result <= '0;
            end
            best_distance    <= '1;
            best_param       <= '0;
            best_slot        <= '0;
            seen_hit         <= 1'b0;
            triangle_counter <= '0;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
